### rtl/owm_pkg.sv
// Shared types and constants for the One-Wire bus master.
package owm_pkg;

  localparam int CFG_W     = 12;
  localparam int REG_COUNT = 8;
  localparam int ADDR_W    = 5;
  localparam int BYTE_W    = 8;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_XFER  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_DEV   = 2'd1,
    ERR_PRES_LEN = 2'd2
  } err_t;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_XFER  = 2'd2;

  localparam logic [2:0] REG_SLOT_LAST       = 3'd0;
  localparam logic [2:0] REG_ZERO_LOW        = 3'd1;
  localparam logic [2:0] REG_ONE_LOW         = 3'd2;
  localparam logic [2:0] REG_READ_THRESHOLD  = 3'd3;
  localparam logic [2:0] REG_RESET_SLOT_LAST = 3'd4;
  localparam logic [2:0] REG_RESET_LOW       = 3'd5;
  localparam logic [2:0] REG_PRESENCE_MIN    = 3'd6;
  localparam logic [2:0] REG_PRESENCE_MAX    = 3'd7;

  localparam logic [CFG_W-1:0] DEF_SLOT_LAST       = 12'd70;
  localparam logic [CFG_W-1:0] DEF_ZERO_LOW        = 12'd65;
  localparam logic [CFG_W-1:0] DEF_ONE_LOW         = 12'd13;
  localparam logic [CFG_W-1:0] DEF_READ_THRESHOLD  = 12'd15;
  localparam logic [CFG_W-1:0] DEF_RESET_SLOT_LAST = 12'd2999;
  localparam logic [CFG_W-1:0] DEF_RESET_LOW       = 12'd499;
  localparam logic [CFG_W-1:0] DEF_PRESENCE_MIN    = 12'd74;
  localparam logic [CFG_W-1:0] DEF_PRESENCE_MAX    = 12'd299;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

### rtl/onewire_bus_master.sv
// One-Wire bus master: timing state machine, register file and result register.
// The result of an item is written to the output register when the item is accepted.
// Throughput: one item per cycle with no gaps while results are taken as they come;
// a result that waits in the single output register holds off the next item.
// Reset (rst_n low, synchronous): master idle, timers cleared, line seen as released,
// configuration registers back to their defaults, output register empty.
module onewire_bus_master #(
  parameter int TIMER_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: action[1:0], tx_byte[9:2], line_high[10], zero fill [15:11]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [owm_pkg::IN_W-1:0]    in_tdata,
  // out_tdata: drive_low[0], busy_res[1], done_res[2], rx_byte[10:3],
  // error_code[12:11], zero fill [15:13]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [owm_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [owm_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import owm_pkg::*;

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [CW-1:0] TMAX_W = CW'((64'd1 << TIMER_BITS) - 64'd1);

  // Configuration registers
  logic [CFG_W-1:0] cfg_r [REG_COUNT];
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = 32'(cfg_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_SLOT_LAST]       <= DEF_SLOT_LAST;
      cfg_r[REG_ZERO_LOW]        <= DEF_ZERO_LOW;
      cfg_r[REG_ONE_LOW]         <= DEF_ONE_LOW;
      cfg_r[REG_READ_THRESHOLD]  <= DEF_READ_THRESHOLD;
      cfg_r[REG_RESET_SLOT_LAST] <= DEF_RESET_SLOT_LAST;
      cfg_r[REG_RESET_LOW]       <= DEF_RESET_LOW;
      cfg_r[REG_PRESENCE_MIN]    <= DEF_PRESENCE_MIN;
      cfg_r[REG_PRESENCE_MAX]    <= DEF_PRESENCE_MAX;
    end else if (cfg_wr) begin
      cfg_r[cfg_idx] <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // Operation state
  mode_t                 mode_r, mode_c, mode_nxt;
  logic [TIMER_BITS-1:0] slot_tick_r, slot_tick_nxt;
  logic [3:0]            bit_index_r, bit_index_nxt;
  logic [BYTE_W-1:0]     tx_shift_r, tx_shift_nxt;
  logic [BYTE_W-1:0]     rx_shift_r, rx_shift_nxt;
  logic                  edge_seen_r, edge_seen_nxt;
  logic [TIMER_BITS-1:0] first_edge_r, first_edge_nxt;
  logic                  line_prev_r;
  err_t                  last_error_r, last_error_nxt;

  // Output register
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic              drive_c, busy_c, done_c;

  logic              in_acc;
  logic [1:0]        action;
  logic [BYTE_W-1:0] tx_byte;
  logic              line_high;
  logic              start;
  logic              rise;

  logic [CW-1:0]         tick_w;
  logic [CW-1:0]         slot_lim_w, reset_lim_w;
  logic [CW-1:0]         raw_slot_w, raw_reset_w;
  logic [TIMER_BITS-1:0] pres_len;
  logic [CW-1:0]         pres_len_w;
  logic [CFG_W-1:0]      low_ticks;
  logic                  rx_bit;
  logic [3:0]            bit_index_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign action    = in_tdata[1:0];
  assign tx_byte   = in_tdata[9:2];
  assign line_high = in_tdata[10];

  assign start = (mode_r == MODE_IDLE) && ((action == ACT_RESET) || (action == ACT_XFER));
  assign rise  = !line_prev_r && line_high;

  // Slot limits saturate to the largest timer value.
  assign raw_slot_w  = CW'(cfg_r[REG_SLOT_LAST]);
  assign raw_reset_w = CW'(cfg_r[REG_RESET_SLOT_LAST]);
  assign slot_lim_w  = (raw_slot_w > TMAX_W) ? TMAX_W : raw_slot_w;
  assign reset_lim_w = (raw_reset_w > TMAX_W) ? TMAX_W : raw_reset_w;

  // Mode in effect for this item: a command taken while idle starts at once.
  always_comb begin
    mode_c = mode_r;
    if (start) begin
      mode_c = (action == ACT_RESET) ? MODE_RESET : MODE_XFER;
    end
  end

  // Next mode
  always_comb begin
    mode_nxt = mode_c;
    if (done_c) begin
      mode_nxt = MODE_IDLE;
    end
  end

  // Datapath and outputs
  always_comb begin
    slot_tick_nxt  = start ? '0 : slot_tick_r;
    bit_index_nxt  = start ? '0 : bit_index_r;
    edge_seen_nxt  = start ? 1'b0 : edge_seen_r;
    first_edge_nxt = start ? '0 : first_edge_r;
    last_error_nxt = start ? ERR_NONE : last_error_r;
    tx_shift_nxt   = (start && action == ACT_XFER) ? tx_byte : tx_shift_r;
    rx_shift_nxt   = (start && action == ACT_XFER) ? '0 : rx_shift_r;

    tick_w        = CW'(slot_tick_nxt);
    pres_len      = slot_tick_nxt - first_edge_nxt;
    pres_len_w    = CW'(pres_len);
    low_ticks     = tx_shift_nxt[0] ? cfg_r[REG_ONE_LOW] : cfg_r[REG_ZERO_LOW];
    rx_bit        = 1'b0;
    bit_index_inc = bit_index_nxt + 4'd1;
    drive_c       = 1'b0;
    busy_c        = 1'b0;
    done_c        = 1'b0;

    case (mode_c)
      MODE_RESET: begin
        busy_c  = 1'b1;
        drive_c = tick_w < CW'(cfg_r[REG_RESET_LOW]);
        if (rise) begin
          if (!edge_seen_nxt) begin
            edge_seen_nxt  = 1'b1;
            first_edge_nxt = slot_tick_nxt;
          end else begin
            // A rise after the recorded edge ends the presence pulse.
            last_error_nxt = ((pres_len_w < CW'(cfg_r[REG_PRESENCE_MIN])) ||
                              (pres_len_w > CW'(cfg_r[REG_PRESENCE_MAX])))
                             ? ERR_PRES_LEN : ERR_NONE;
            done_c = 1'b1;
          end
        end
        if (!done_c && (tick_w >= reset_lim_w)) begin
          last_error_nxt = ERR_NO_DEV;
          done_c         = 1'b1;
        end
        if (done_c) begin
          slot_tick_nxt = '0;
          edge_seen_nxt = 1'b0;
        end else begin
          slot_tick_nxt = slot_tick_nxt + 1'b1;
        end
      end
      MODE_XFER: begin
        busy_c  = 1'b1;
        drive_c = tick_w < CW'(low_ticks);
        if (rise && !edge_seen_nxt) begin
          edge_seen_nxt  = 1'b1;
          first_edge_nxt = slot_tick_nxt;
        end
        if (tick_w >= slot_lim_w) begin
          rx_bit = edge_seen_nxt &&
                   (CW'(first_edge_nxt) <= CW'(cfg_r[REG_READ_THRESHOLD]));
          rx_shift_nxt  = {rx_bit, rx_shift_nxt[BYTE_W-1:1]};
          tx_shift_nxt  = {1'b0, tx_shift_nxt[BYTE_W-1:1]};
          bit_index_nxt = bit_index_inc;
          edge_seen_nxt = 1'b0;
          slot_tick_nxt = '0;
          if (bit_index_inc >= BITS_PER_BYTE) begin
            done_c        = 1'b1;
            bit_index_nxt = '0;
          end
        end else begin
          slot_tick_nxt = slot_tick_nxt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      slot_tick_r  <= '0;
      bit_index_r  <= '0;
      tx_shift_r   <= '0;
      rx_shift_r   <= '0;
      edge_seen_r  <= 1'b0;
      first_edge_r <= '0;
      line_prev_r  <= 1'b1;
      last_error_r <= ERR_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r       <= mode_nxt;
        slot_tick_r  <= slot_tick_nxt;
        bit_index_r  <= bit_index_nxt;
        tx_shift_r   <= tx_shift_nxt;
        rx_shift_r   <= rx_shift_nxt;
        edge_seen_r  <= edge_seen_nxt;
        first_edge_r <= first_edge_nxt;
        line_prev_r  <= line_high;
        last_error_r <= last_error_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= OUT_W'({last_error_nxt, rx_shift_nxt, done_c, busy_c, drive_c});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A finished operation is still reported as busy on its last tick.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r[2] || out_data_r[1]))
    else $error("done without busy in result");

  // The slot timer rests at zero and no edge is recorded whenever the master is idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (slot_tick_r == '0) && !edge_seen_r)
    else $error("idle master with running slot timer");

  // The bit counter never reaches a full byte between items.
  assert property (@(posedge clk) disable iff (!rst_n)
    bit_index_r < BITS_PER_BYTE)
    else $error("bit counter out of range");

  // An item taken while idle that starts no operation yields a result that is not busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (mode_r == MODE_IDLE) && (action != ACT_RESET) && (action != ACT_XFER))
    |=> (out_valid_r && !out_data_r[1]))
    else $error("idle tick reported busy");

endmodule

### dv/onewire_bus_master_tb.sv
// Self-checking testbench for the One-Wire bus master: bus-level stimulus and a per-tick model.
`timescale 1ns / 1ps

module onewire_bus_master_tb;
  import owm_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_RANDOM    = -1;
  localparam int          HOLD_JITTER    = -2;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    err_t       error_code;
  } tick_result_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  onewire_bus_master u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timing registers as the master should hold them, and its own state.
  logic [CFG_W-1:0] cfg_shadow [REG_COUNT];
  mode_t            m_mode;
  logic [CFG_W-1:0] m_tick;
  logic [3:0]       m_bit;
  logic [7:0]       m_tx;
  logic [7:0]       m_rx;
  logic             m_edge;
  logic [CFG_W-1:0] m_first_edge;
  logic             m_line_prev;
  err_t             m_err;

  tick_result_t master_outputs_due [$];
  tick_result_t due_now;
  int           mismatches     = 0;
  int           items_sent     = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles   = 0;
  logic         last_line      = 1'b1;

  function automatic void master_reset_state();
    cfg_shadow[REG_SLOT_LAST]       = DEF_SLOT_LAST;
    cfg_shadow[REG_ZERO_LOW]        = DEF_ZERO_LOW;
    cfg_shadow[REG_ONE_LOW]         = DEF_ONE_LOW;
    cfg_shadow[REG_READ_THRESHOLD]  = DEF_READ_THRESHOLD;
    cfg_shadow[REG_RESET_SLOT_LAST] = DEF_RESET_SLOT_LAST;
    cfg_shadow[REG_RESET_LOW]       = DEF_RESET_LOW;
    cfg_shadow[REG_PRESENCE_MIN]    = DEF_PRESENCE_MIN;
    cfg_shadow[REG_PRESENCE_MAX]    = DEF_PRESENCE_MAX;
    m_mode       = MODE_IDLE;
    m_tick       = '0;
    m_bit        = '0;
    m_tx         = '0;
    m_rx         = '0;
    m_edge       = 1'b0;
    m_first_edge = '0;
    m_line_prev  = 1'b1;
    m_err        = ERR_NONE;
  endfunction

  // One bus tick of the master: returns the outputs for that tick.
  function automatic tick_result_t master_tick(input logic [1:0] act, input logic [7:0] txb,
                                               input logic line);
    tick_result_t     res;
    logic             rise;
    logic [CFG_W-1:0] low_time;
    logic [CFG_W-1:0] pres_len;
    logic             bit_val;
    res  = '0;
    rise = !m_line_prev && line;
    if (m_mode == MODE_IDLE && (act == ACT_RESET || act == ACT_XFER)) begin
      m_mode       = (act == ACT_RESET) ? MODE_RESET : MODE_XFER;
      m_tick       = '0;
      m_bit        = '0;
      m_edge       = 1'b0;
      m_first_edge = '0;
      m_err        = ERR_NONE;
      if (act == ACT_XFER) begin
        m_tx = txb;
        m_rx = '0;
      end
    end
    if (m_mode == MODE_RESET) begin
      res.busy      = 1'b1;
      res.drive_low = (m_tick < cfg_shadow[REG_RESET_LOW]);
      if (rise) begin
        if (!m_edge) begin
          m_edge       = 1'b1;
          m_first_edge = m_tick;
        end else begin
          // Release to end of presence, modulo the timer width.
          pres_len = m_tick - m_first_edge;
          m_err    = (pres_len < cfg_shadow[REG_PRESENCE_MIN] ||
                      pres_len > cfg_shadow[REG_PRESENCE_MAX]) ? ERR_PRES_LEN : ERR_NONE;
          res.done = 1'b1;
        end
      end
      if (!res.done && m_tick >= cfg_shadow[REG_RESET_SLOT_LAST]) begin
        m_err    = ERR_NO_DEV;
        res.done = 1'b1;
      end
      if (res.done) begin
        m_mode = MODE_IDLE;
        m_tick = '0;
        m_edge = 1'b0;
      end else begin
        m_tick = m_tick + 1'b1;
      end
    end else if (m_mode == MODE_XFER) begin
      low_time      = m_tx[0] ? cfg_shadow[REG_ONE_LOW] : cfg_shadow[REG_ZERO_LOW];
      res.busy      = 1'b1;
      res.drive_low = (m_tick < low_time);
      if (rise && !m_edge) begin
        m_edge       = 1'b1;
        m_first_edge = m_tick;
      end
      if (m_tick >= cfg_shadow[REG_SLOT_LAST]) begin
        bit_val = m_edge && (m_first_edge <= cfg_shadow[REG_READ_THRESHOLD]);
        m_rx    = {bit_val, m_rx[7:1]};
        m_tx    = {1'b0, m_tx[7:1]};
        m_bit   = m_bit + 1'b1;
        m_edge  = 1'b0;
        m_tick  = '0;
        if (m_bit >= BITS_PER_BYTE) begin
          res.done = 1'b1;
          m_mode   = MODE_IDLE;
          m_bit    = '0;
        end
      end else begin
        m_tick = m_tick + 1'b1;
      end
    end
    m_line_prev    = line;
    res.rx_byte    = m_rx;
    res.error_code = m_err;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $realtime, name, want_v, got_v);
    end
  endfunction

  // Result checking and prediction share one process, so a result is always
  // compared before the item accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (master_outputs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result arrived with none expected", $realtime);
        end else begin
          due_now = master_outputs_due.pop_front();
          check_field("drive_low", due_now.drive_low, out_tdata[0]);
          check_field("busy_res", due_now.busy, out_tdata[1]);
          check_field("done_res", due_now.done, out_tdata[2]);
          check_field("rx_byte", due_now.rx_byte, out_tdata[10:3]);
          check_field("error_code", due_now.error_code, out_tdata[12:11]);
        end
      end
      if (in_tvalid && in_tready)
        master_outputs_due.push_back(master_tick(in_tdata[1:0], in_tdata[9:2], in_tdata[10]));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int cfg_val(input logic [2:0] idx);
    return int'(cfg_shadow[idx]);
  endfunction

  // Commands thrown in while the master is busy; they must be ignored.
  function automatic logic [1:0] busy_noise_action();
    return ($urandom_range(15) == 0) ? 2'($urandom_range(3)) : ACT_TICK;
  endfunction

  task automatic send_tick(input logic [1:0] act, input logic [7:0] txb, input logic line);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-11){1'b0}}, line, txb, act};
    do @(posedge clk); while (!in_tready);
    last_line = line;
    items_sent++;
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (master_outputs_due.size() != 0);
  endtask

  // Bring the master to idle with the line released and every result taken.
  task automatic settle_master();
    wait_results();
    while (m_mode != MODE_IDLE) send_tick(ACT_TICK, 8'($urandom_range(255)), 1'b1);
    wait_results();
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(32-CFG_W){1'b0}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_shadow[idx] = val;
  endtask

  task automatic cfg_read_check(input logic [2:0] idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    check_field("register readback", cfg_shadow[idx], cfg_prdata);
  endtask

  task automatic read_all_registers();
    for (int i = 0; i < REG_COUNT; i++) cfg_read_check(3'(i));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_registers(input int sl, input int zl, input int ol, input int th,
                                   input int rsl, input int rl, input int pmn, input int pmx);
    logic [CFG_W-1:0] vals [REG_COUNT];
    vals = '{CFG_W'(sl), CFG_W'(zl), CFG_W'(ol), CFG_W'(th),
             CFG_W'(rsl), CFG_W'(rl), CFG_W'(pmn), CFG_W'(pmx)};
    settle_master();
    for (int i = 0; i < REG_COUNT; i++) cfg_write(3'(i), vals[i]);
    read_all_registers();
  endtask

  // Reset and presence: the master holds the line low, then a device waits
  // wait_ticks after release and pulls low for pulse_ticks (none when zero).
  task automatic run_reset(input int wait_ticks, input int pulse_ticks);
    int   rlow;
    int   rlast;
    int   rises;
    int   pres_start;
    logic line;
    logic prev;
    rlow       = cfg_val(REG_RESET_LOW);
    rlast      = cfg_val(REG_RESET_SLOT_LAST);
    pres_start = rlow + wait_ticks;
    prev       = last_line;
    rises      = 0;
    for (int t = 0; t <= rlast && rises < 2; t++) begin
      line = !(t < rlow || (pulse_ticks > 0 && t >= pres_start && t < pres_start + pulse_ticks));
      if (line && !prev) rises++;
      prev = line;
      send_tick((t == 0) ? ACT_RESET : busy_noise_action(), 8'($urandom_range(255)), line);
    end
  endtask

  // Byte transfer: in each slot a device holds the line low for a while. A one
  // in answer lets the line rise with the master; a zero holds it for zero_hold
  // ticks, or for a random time past the threshold. Jitter ignores answer.
  task automatic run_transfer(input logic [7:0] txb, input logic [7:0] answer,
                              input int zero_hold);
    int   sl;
    int   thr;
    int   low;
    int   hold;
    logic line;
    sl  = cfg_val(REG_SLOT_LAST);
    thr = cfg_val(REG_READ_THRESHOLD);
    for (int s = 0; s < 8; s++) begin
      low = txb[s] ? cfg_val(REG_ONE_LOW) : cfg_val(REG_ZERO_LOW);
      if (zero_hold == HOLD_JITTER) hold = $urandom_range(sl + 2);
      else if (answer[s]) hold = 0;
      else if (zero_hold >= 0) hold = zero_hold;
      else hold = $urandom_range(sl + 1, thr + 1);
      for (int t = 0; t <= sl; t++) begin
        line = !(t < low || t < hold);
        if (s == 0 && t == 0) send_tick(ACT_XFER, txb, line);
        else send_tick(busy_noise_action(), 8'($urandom_range(255)), line);
      end
    end
  endtask

  task automatic run_noise(input int count);
    for (int i = 0; i < count; i++)
      send_tick(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic test_register_defaults();
    read_all_registers();
    send_tick(ACT_TICK, 8'h00, 1'b1);
    send_tick(ACT_UNUSED, 8'hFF, 1'b0);
    send_tick(ACT_UNUSED, 8'h00, 1'b1);
    send_tick(ACT_TICK, 8'hFF, 1'b1);
  endtask

  task automatic test_directed_reset();
    program_registers(3, 3, 1, 1, 20, 4, 3, 6);
    run_reset(2, 3);
    run_reset(1, 1);
    run_reset(4, 5);
    run_reset(0, 0);
    // Presence ends exactly on the last tick of the reset window.
    run_reset(8, 8);
  endtask

  task automatic test_directed_transfer();
    run_transfer(8'h00, 8'hFF, HOLD_RANDOM);
    run_transfer(8'hFF, 8'hFF, HOLD_RANDOM);
    // Zero answers hold the line until the last tick of the slot.
    run_transfer(8'hFF, 8'h0F, 3);
    run_transfer(8'hA5, 8'h3C, HOLD_RANDOM);
    run_noise(12);
  endtask

  task automatic test_low_extremes();
    program_registers(1, 0, 0, 0, 1, 0, 0, 0);
    run_transfer(8'h5A, 8'hC3, HOLD_JITTER);
    run_reset(0, 0);
    run_reset(1, 1);
    run_noise(20);
  endtask

  // Top values for low times, threshold, reset window and presence bounds; the
  // slot stays short and the device answers early so the run stays short.
  task automatic test_high_extremes();
    program_registers(5, 4095, 4095, 4095, 4095, 3, 4095, 4095);
    run_reset(1, 1);
    run_transfer(8'h96, 8'hFF, HOLD_RANDOM);
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct, input int count);
    int sl;
    int rsl;
    int pmn;
    int pmx;
    int len;
    int w;
    int stop_at;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 3; k++) begin
      sl  = $urandom_range(1, 10);
      rsl = $urandom_range(6, 40);
      pmn = $urandom_range(0, 12);
      pmx = $urandom_range(0, 20);
      program_registers(sl, $urandom_range(0, sl + 1), $urandom_range(0, sl),
                        $urandom_range(0, sl + 1), rsl, $urandom_range(0, rsl / 2), pmn, pmx);
      stop_at = items_sent + count / 3;
      while (items_sent < stop_at) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            run_transfer(8'($urandom_range(255)), 8'($urandom_range(255)),
                         ($urandom_range(3) == 0) ? HOLD_JITTER : HOLD_RANDOM);
          end
          4, 5, 6: begin
            // Half the time aim the presence length inside the accepted window.
            if (pmn <= pmx && pmx >= 2 && $urandom_range(1) == 1)
              len = $urandom_range(pmx, (pmn < 2) ? 2 : pmn);
            else
              len = $urandom_range(2, 24);
            w = $urandom_range(1, len - 1);
            run_reset(w, ($urandom_range(6) == 0) ? 0 : len - w);
          end
          7: run_noise($urandom_range(3, 20));
          8: wait_results();
          default: repeat ($urandom_range(1, 4)) send_tick(ACT_TICK, 8'h00, 1'b1);
        endcase
      end
    end
  endtask

  initial begin
    master_reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_directed_reset();
    test_directed_transfer();
    test_low_extremes();
    test_high_extremes();
    test_random_traffic(0, 0, 100);
    test_random_traffic(88, 0, 100);
    test_random_traffic(0, 88, 100);
    test_random_traffic(30, 30, 100);
    wait_results();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && master_outputs_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/owm_pkg.sv
rtl/onewire_bus_master.sv
dv/onewire_bus_master_tb.sv
